FILE: hw/rtl/sound_cpu_io_timer_registers_assert.svh
// assertion macros for the sound cpu register page
`ifndef SOUND_CPU_IO_TIMER_REGISTERS_ASSERT_SVH
`define SOUND_CPU_IO_TIMER_REGISTERS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, quiet during reset
`define SCIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sound cpu register page: same-cycle check failed");
// next-cycle implication, sampled on clk_i, quiet during reset
`define SCIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sound cpu register page: next-cycle check failed");
`else
`define SCIT_ASSERT_NOW(label, ante, cons)
`define SCIT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/scit_pkg.sv
`timescale 1ns / 1ps

package scit_pkg;

  // field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned SrcW    = 2;
  localparam int unsigned TOutW   = 4;
  localparam int unsigned PresW   = 3;

  localparam int unsigned NumPorts  = 4;
  localparam int unsigned NumAux    = 2;
  localparam int unsigned NumTimers = 3;

  // prescaler reload value for timers 0 and 1
  localparam logic [PresW-1:0] PrescaleDivide = PresW'(4);

  // operation codes of an input item
  typedef enum logic [ModeW-1:0] {
    MODE_SND_RD   = 3'd0,
    MODE_SND_WR   = 3'd1,
    MODE_HOST_RD  = 3'd2,
    MODE_HOST_WR  = 3'd3,
    MODE_PRES_TCK = 3'd4,
    MODE_FAST_TCK = 3'd5
  } mode_e;

  // where the byte of an access lives
  typedef enum logic [SrcW-1:0] {
    SRC_BLOCK = 2'd0,
    SRC_RAM   = 2'd1,
    SRC_IPL   = 2'd2,
    SRC_DSP   = 2'd3
  } src_e;

  // register page location and offsets within it
  localparam logic [11:0] PageBase = 12'h00F;
  localparam logic [AddrW-1:0] IplBase = 16'hFFC0;

  localparam logic [3:0] REG_CONTROL  = 4'h1;
  localparam logic [3:0] REG_DSP_ADDR = 4'h2;
  localparam logic [3:0] REG_DSP_DATA = 4'h3;
  localparam logic [3:0] REG_PORT0    = 4'h4;
  localparam logic [3:0] REG_PORT1    = 4'h5;
  localparam logic [3:0] REG_PORT2    = 4'h6;
  localparam logic [3:0] REG_PORT3    = 4'h7;
  localparam logic [3:0] REG_AUX0     = 4'h8;
  localparam logic [3:0] REG_AUX1     = 4'h9;
  localparam logic [3:0] REG_TARGET0  = 4'hA;
  localparam logic [3:0] REG_TARGET1  = 4'hB;
  localparam logic [3:0] REG_TARGET2  = 4'hC;
  localparam logic [3:0] REG_OUT0     = 4'hD;
  localparam logic [3:0] REG_OUT1     = 4'hE;
  localparam logic [3:0] REG_OUT2     = 4'hF;

  // control register layout
  localparam logic [DataW-1:0] CtrlReset = 8'h80;
  localparam logic [DataW-1:0] CtrlMask  = 8'h87;
  localparam int unsigned CtrlIplBit   = 7;
  localparam int unsigned CtrlClrLoBit = 4;
  localparam int unsigned CtrlClrHiBit = 5;

  localparam logic [DataW-1:0] AuxReset = 8'hFF;

  // per-timer strobes from the register decode
  typedef struct packed {
    logic             tick;
    logic             clr_all;
    logic             clr_out;
    logic             tgt_we;
    logic [DataW-1:0] tgt_data;
  } timer_ctl_t;

endpackage

FILE: hw/rtl/scit_in_if.sv
`timescale 1ns / 1ps

interface scit_in_if;
  logic                           valid;
  logic                           ready;
  logic [scit_pkg::ModeW-1:0]     mode;
  logic [scit_pkg::AddrW-1:0]     address;
  logic [scit_pkg::DataW-1:0]     write_data;

  modport source (output valid, mode, address, write_data, input ready);
  modport sink   (input valid, mode, address, write_data, output ready);
endinterface

FILE: hw/rtl/scit_out_if.sv
`timescale 1ns / 1ps

interface scit_out_if;
  logic                           valid;
  logic                           ready;
  logic [scit_pkg::DataW-1:0]     read_data;
  logic [scit_pkg::SrcW-1:0]      data_source;
  logic [scit_pkg::DataW-1:0]     dsp_address;
  logic                           dsp_wr;

  modport source (output valid, read_data, data_source, dsp_address, dsp_wr, input ready);
  modport sink   (input valid, read_data, data_source, dsp_address, dsp_wr, output ready);
endinterface

FILE: hw/rtl/scit_timer.sv
`timescale 1ns / 1ps

module scit_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        enable_i,
  input  scit_pkg::timer_ctl_t        ctl_i,
  output logic [scit_pkg::TOutW-1:0]  out_o
);

  logic [scit_pkg::DataW-1:0] tgt_q, tgt_d;
  logic [scit_pkg::DataW-1:0] cnt_q, cnt_d;
  logic [scit_pkg::TOutW-1:0] out_q, out_d;
  logic [scit_pkg::DataW-1:0] cnt_inc;

  // load the target, clear on request, count up on an enabled tick, wrap to zero on a target match
  always_comb begin
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    cnt_inc = cnt_q + scit_pkg::DataW'(1);
    if (ctl_i.tgt_we) begin
      tgt_d = ctl_i.tgt_data;
    end
    if (ctl_i.clr_all) begin
      cnt_d = '0;
      out_d = '0;
    end
    if (ctl_i.clr_out) begin
      out_d = '0;
    end
    if (ctl_i.tick && enable_i) begin
      if (cnt_inc == tgt_q) begin
        cnt_d = '0;
        out_d = out_q + scit_pkg::TOutW'(1);
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      cnt_q <= '0;
      out_q <= '0;
    end else begin
      tgt_q <= tgt_d;
      cnt_q <= cnt_d;
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: hw/rtl/sound_cpu_io_timer_registers.sv
`timescale 1ns / 1ps

// Register page of the sound CPU at 0x00F0-0x00FF with the host side of the
// four mailbox ports and three interval timers. Every mode (sound read or
// write, host read or write, prescaler tick, fast tick) gives exactly one
// result. The block takes one transfer per clock cycle while the receiver takes
// each result: state is updated at the accepting edge and the result sits in a
// single output register, so it is offered in the cycle after acceptance and a
// new transfer is taken in the same cycle the previous result is taken. There is
// no clearing pass after reset; the block is ready as soon as reset is released.
module sound_cpu_io_timer_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  scit_in_if.sink     in_i,
  scit_out_if.source  out_o
);

  `include "sound_cpu_io_timer_registers_assert.svh"

  logic                         accept;
  logic                         page_hit;
  logic [3:0]                   reg_idx;
  logic [1:0]                   tsel;

  logic [scit_pkg::DataW-1:0]   ctrl_q, ctrl_d;
  logic [scit_pkg::DataW-1:0]   dsp_addr_q, dsp_addr_d;
  logic [scit_pkg::DataW-1:0]   h2s_q [scit_pkg::NumPorts];
  logic [scit_pkg::DataW-1:0]   h2s_d [scit_pkg::NumPorts];
  logic [scit_pkg::DataW-1:0]   s2h_q [scit_pkg::NumPorts];
  logic [scit_pkg::DataW-1:0]   s2h_d [scit_pkg::NumPorts];
  logic [scit_pkg::DataW-1:0]   aux_q [scit_pkg::NumAux];
  logic [scit_pkg::DataW-1:0]   aux_d [scit_pkg::NumAux];
  logic [scit_pkg::PresW-1:0]   pres_q, pres_d;
  logic [scit_pkg::PresW-1:0]   pres_dec;

  scit_pkg::timer_ctl_t         tmr_ctl [scit_pkg::NumTimers];
  logic [scit_pkg::TOutW-1:0]   tmr_out [scit_pkg::NumTimers];

  logic [scit_pkg::DataW-1:0]   rd_d;
  scit_pkg::src_e               src_d;
  logic [scit_pkg::DataW-1:0]   daddr_d;
  logic                         dwr_d;

  logic                         out_valid_q;
  logic [scit_pkg::DataW-1:0]   rd_q;
  logic [scit_pkg::SrcW-1:0]    src_q;
  logic [scit_pkg::DataW-1:0]   daddr_q;
  logic                         dwr_q;

  // handshake: take a transfer whenever the result register is free or drains
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // page decode
  assign page_hit = (in_i.address[scit_pkg::AddrW-1:4] == scit_pkg::PageBase);
  assign reg_idx  = in_i.address[3:0];

  // register page decode and next state
  always_comb begin
    ctrl_d     = ctrl_q;
    dsp_addr_d = dsp_addr_q;
    h2s_d      = h2s_q;
    s2h_d      = s2h_q;
    aux_d      = aux_q;
    pres_d     = pres_q;
    pres_dec   = pres_q - scit_pkg::PresW'(1);
    tsel       = '0;
    rd_d       = '0;
    src_d      = scit_pkg::SRC_BLOCK;
    daddr_d    = '0;
    dwr_d      = 1'b0;
    for (int t = 0; t < scit_pkg::NumTimers; t++) begin
      tmr_ctl[t]          = '0;
      tmr_ctl[t].tgt_data = in_i.write_data;
    end

    case (in_i.mode)
      scit_pkg::MODE_SND_RD: begin
        if (page_hit) begin
          case (reg_idx)
            scit_pkg::REG_DSP_ADDR: rd_d = dsp_addr_q;
            scit_pkg::REG_DSP_DATA: begin
              src_d   = scit_pkg::SRC_DSP;
              daddr_d = dsp_addr_q;
            end
            scit_pkg::REG_PORT0, scit_pkg::REG_PORT1,
            scit_pkg::REG_PORT2, scit_pkg::REG_PORT3: begin
              rd_d = h2s_q[in_i.address[1:0]];
            end
            scit_pkg::REG_AUX0, scit_pkg::REG_AUX1: begin
              rd_d = aux_q[in_i.address[0]];
            end
            scit_pkg::REG_OUT0, scit_pkg::REG_OUT1, scit_pkg::REG_OUT2: begin
              // timer outputs clear on read
              tsel = 2'(reg_idx - scit_pkg::REG_OUT0);
              rd_d = scit_pkg::DataW'(tmr_out[tsel]);
              tmr_ctl[tsel].clr_out = accept;
            end
            default: ;
          endcase
        end else if ((in_i.address >= scit_pkg::IplBase) && ctrl_q[scit_pkg::CtrlIplBit]) begin
          src_d = scit_pkg::SRC_IPL;
        end else begin
          src_d = scit_pkg::SRC_RAM;
        end
      end

      scit_pkg::MODE_SND_WR: begin
        // ram behind the page is always written too
        src_d = scit_pkg::SRC_RAM;
        if (page_hit) begin
          case (reg_idx)
            scit_pkg::REG_CONTROL: begin
              // restart every timer whose enable rises
              for (int t = 0; t < scit_pkg::NumTimers; t++) begin
                tmr_ctl[t].clr_all = accept && !ctrl_q[t] && in_i.write_data[t];
              end
              if (in_i.write_data[scit_pkg::CtrlClrLoBit]) begin
                h2s_d[0] = '0;
                h2s_d[1] = '0;
              end
              if (in_i.write_data[scit_pkg::CtrlClrHiBit]) begin
                h2s_d[2] = '0;
                h2s_d[3] = '0;
              end
              ctrl_d = in_i.write_data & scit_pkg::CtrlMask;
            end
            scit_pkg::REG_DSP_ADDR: dsp_addr_d = in_i.write_data;
            scit_pkg::REG_DSP_DATA: begin
              daddr_d = dsp_addr_q;
              dwr_d   = 1'b1;
            end
            scit_pkg::REG_PORT0, scit_pkg::REG_PORT1,
            scit_pkg::REG_PORT2, scit_pkg::REG_PORT3: begin
              s2h_d[in_i.address[1:0]] = in_i.write_data;
            end
            scit_pkg::REG_AUX0, scit_pkg::REG_AUX1: begin
              aux_d[in_i.address[0]] = in_i.write_data;
            end
            scit_pkg::REG_TARGET0, scit_pkg::REG_TARGET1, scit_pkg::REG_TARGET2: begin
              tsel = 2'(reg_idx - scit_pkg::REG_TARGET0);
              tmr_ctl[tsel].tgt_we = accept;
            end
            default: ;
          endcase
        end
      end

      scit_pkg::MODE_HOST_RD: rd_d = s2h_q[in_i.address[1:0]];

      scit_pkg::MODE_HOST_WR: h2s_d[in_i.address[1:0]] = in_i.write_data;

      scit_pkg::MODE_PRES_TCK: begin
        // divide-by-n prescaler feeds timers 0 and 1
        if (pres_dec == '0) begin
          pres_d             = scit_pkg::PrescaleDivide;
          tmr_ctl[0].tick    = accept;
          tmr_ctl[1].tick    = accept;
        end else begin
          pres_d = pres_dec;
        end
      end

      scit_pkg::MODE_FAST_TCK: tmr_ctl[2].tick = accept;

      default: ;
    endcase
  end

  // timers
  for (genvar g = 0; g < scit_pkg::NumTimers; g++) begin : g_timer
    scit_timer u_timer (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .enable_i (ctrl_q[g]),
      .ctl_i    (tmr_ctl[g]),
      .out_o    (tmr_out[g])
    );
  end

  // register page state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= scit_pkg::CtrlReset;
      dsp_addr_q <= '0;
      pres_q     <= scit_pkg::PrescaleDivide;
      for (int i = 0; i < scit_pkg::NumPorts; i++) begin
        h2s_q[i] <= '0;
        s2h_q[i] <= '0;
      end
      for (int i = 0; i < scit_pkg::NumAux; i++) begin
        aux_q[i] <= scit_pkg::AuxReset;
      end
    end else if (accept) begin
      ctrl_q     <= ctrl_d;
      dsp_addr_q <= dsp_addr_d;
      pres_q     <= pres_d;
      h2s_q      <= h2s_d;
      s2h_q      <= s2h_d;
      aux_q      <= aux_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q    <= rd_d;
      src_q   <= src_d;
      daddr_q <= daddr_d;
      dwr_q   <= dwr_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = rd_q;
  assign out_o.data_source = src_q;
  assign out_o.dsp_address = daddr_q;
  assign out_o.dsp_wr      = dwr_q;

  // checks
  `SCIT_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_q)
  `SCIT_ASSERT_NOW(a_dsp_write_via_ram, out_valid_q && dwr_q, src_q == scit_pkg::SRC_RAM)
  `SCIT_ASSERT_NEXT(a_out0_clears_on_read, accept && (in_i.mode == scit_pkg::MODE_SND_RD) && page_hit && (reg_idx == scit_pkg::REG_OUT0), tmr_out[0] == '0)
  `SCIT_ASSERT_NEXT(a_ctrl_clears_low_ports, accept && (in_i.mode == scit_pkg::MODE_SND_WR) && page_hit && (reg_idx == scit_pkg::REG_CONTROL) && in_i.write_data[scit_pkg::CtrlClrLoBit], (h2s_q[0] == '0) && (h2s_q[1] == '0))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import scit_pkg::*;

  // the spare register at the bottom of the page, no function in this block
  localparam logic [3:0] REG_SPARE = 4'h0;
  localparam int RandomItems = 110;
  localparam int HoldCycles = 80;
  localparam int MaxReports = 50;

  // sound cpu register page: prediction and store of expected replies
  class page_predictor;
    typedef struct {
      logic [DataW-1:0] rd;
      src_e             src;
      logic [DataW-1:0] daddr;
      logic             dwr;
    } reply_t;

    reply_t           expected_replies[$];
    logic [DataW-1:0] ctrl;
    logic [DataW-1:0] dsp_addr;
    logic [DataW-1:0] h2s [NumPorts];
    logic [DataW-1:0] s2h [NumPorts];
    logic [DataW-1:0] aux [NumAux];
    logic [DataW-1:0] ttarget [NumTimers];
    logic [DataW-1:0] tcount [NumTimers];
    logic [TOutW-1:0] tout [NumTimers];
    logic [PresW-1:0] prescale;
    int               by_mode [8];
    int               periods;
    int               replies;
    int               errors;

    function new();
      ctrl     = CtrlReset;
      dsp_addr = '0;
      prescale = PrescaleDivide;
      for (int i = 0; i < NumPorts; i++) begin
        h2s[i] = '0;
        s2h[i] = '0;
      end
      for (int i = 0; i < NumAux; i++) aux[i] = AuxReset;
      for (int i = 0; i < NumTimers; i++) begin
        ttarget[i] = '0;
        tcount[i]  = '0;
        tout[i]    = '0;
      end
      foreach (by_mode[i]) by_mode[i] = 0;
      periods = 0;
      replies = 0;
      errors  = 0;
    endfunction

    // one enabled timer step, wrapping to zero on a target match
    function void advance(int t);
      if (ctrl[t]) begin
        tcount[t] = tcount[t] + 8'd1;
        if (tcount[t] == ttarget[t]) begin
          tcount[t] = '0;
          tout[t]   = tout[t] + 4'd1;
          periods++;
        end
      end
    endfunction

    // work out the reply of one accepted transfer and update the page
    function void note_access(mode_e m, logic [AddrW-1:0] a, logic [DataW-1:0] v);
      reply_t     r;
      logic [3:0] off;
      bit         on_page;
      int         t;
      r.rd    = '0;
      r.src   = SRC_BLOCK;
      r.daddr = '0;
      r.dwr   = 1'b0;
      off     = a[3:0];
      on_page = (a[AddrW-1:4] == PageBase);
      by_mode[int'(m)]++;
      case (m)
        MODE_SND_RD: begin
          if (on_page) begin
            case (off)
              REG_DSP_ADDR: r.rd = dsp_addr;
              REG_DSP_DATA: begin
                r.src   = SRC_DSP;
                r.daddr = dsp_addr;
              end
              REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: r.rd = h2s[off[1:0]];
              REG_AUX0, REG_AUX1: r.rd = aux[off[0]];
              REG_OUT0, REG_OUT1, REG_OUT2: begin
                t      = int'(off - REG_OUT0);
                r.rd   = {4'b0000, tout[t]};
                tout[t] = '0;
              end
              default: ;
            endcase
          end else if (a >= IplBase && ctrl[CtrlIplBit]) begin
            r.src = SRC_IPL;
          end else begin
            r.src = SRC_RAM;
          end
        end
        MODE_SND_WR: begin
          // ram always takes the byte as well
          r.src = SRC_RAM;
          if (on_page) begin
            case (off)
              REG_CONTROL: begin
                for (int i = 0; i < NumTimers; i++) begin
                  if (!ctrl[i] && v[i]) begin
                    tcount[i] = '0;
                    tout[i]   = '0;
                  end
                end
                if (v[CtrlClrLoBit]) begin
                  h2s[0] = '0;
                  h2s[1] = '0;
                end
                if (v[CtrlClrHiBit]) begin
                  h2s[2] = '0;
                  h2s[3] = '0;
                end
                ctrl = v & CtrlMask;
              end
              REG_DSP_ADDR: dsp_addr = v;
              REG_DSP_DATA: begin
                r.daddr = dsp_addr;
                r.dwr   = 1'b1;
              end
              REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: s2h[off[1:0]] = v;
              REG_AUX0, REG_AUX1: aux[off[0]] = v;
              REG_TARGET0, REG_TARGET1, REG_TARGET2: ttarget[int'(off - REG_TARGET0)] = v;
              default: ;
            endcase
          end
        end
        MODE_HOST_RD: r.rd = s2h[a[1:0]];
        MODE_HOST_WR: h2s[a[1:0]] = v;
        MODE_PRES_TCK: begin
          prescale = prescale - 3'd1;
          if (prescale == '0) begin
            prescale = PrescaleDivide;
            advance(0);
            advance(1);
          end
        end
        MODE_FAST_TCK: advance(2);
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MaxReports) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one accepted reply with the oldest prediction
    task check_reply(logic [DataW-1:0] rd, logic [SrcW-1:0] src, logic [DataW-1:0] daddr,
                     logic dwr);
      reply_t e;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply rd=%02h src=%0d with nothing outstanding", rd, src));
        return;
      end
      e = expected_replies.pop_front();
      replies++;
      if (rd !== e.rd)
        report($sformatf("read_data %02h, predicted %02h", rd, e.rd));
      if (src !== e.src)
        report($sformatf("data_source %0d, predicted %0d", src, e.src));
      if (daddr !== e.daddr)
        report($sformatf("dsp_address %02h, predicted %02h", daddr, e.daddr));
      if (dwr !== e.dwr)
        report($sformatf("dsp_wr %0b, predicted %0b", dwr, e.dwr));
    endtask

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scit_in_if  in_if ();
  scit_out_if out_if ();

  sound_cpu_io_timer_registers uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  page_predictor sb;
  int            items_sent;
  int            burst_left;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both channels at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_access(mode_e'(in_if.mode), in_if.address, in_if.write_data);
      if (out_if.valid && out_if.ready)
        sb.check_reply(out_if.read_data, out_if.data_source, out_if.dsp_address,
                       out_if.dsp_wr);
    end
  end

  // receiver: stall patterns in segments, with long hold-offs
  initial begin : rx_side
    int seg;
    int style;
    int len;
    out_if.ready = 1'b0;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      if (seg == 4 || $urandom_range(0, 11) == 0) begin
        repeat (HoldCycles) begin
          @(posedge clk_i);
          out_if.ready <= 1'b0;
        end
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(10, 60);
        for (int i = 0; i < len; i++) begin
          @(posedge clk_i);
          case (style)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= (i % 3 == 0);
            default: out_if.ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
      seg++;
    end
  end

  // a run ends after two milliseconds of simulated time at most
  initial begin : watchdog
    #2ms;
    $display("sound_cpu_io_timer_registers verification failed");
    $finish;
  end

  function automatic logic [AddrW-1:0] page_addr(logic [3:0] off);
    return {PageBase, off};
  endfunction

  // offer one transfer and wait for it; bursts end in a random gap
  task automatic send(mode_e m, logic [AddrW-1:0] a, logic [DataW-1:0] d);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.address    <= a;
    in_if.write_data <= d;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 60);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // one random sequence, mostly well-formed register traffic
  task automatic random_sequence();
    int               kind;
    int               n;
    int               t;
    logic [1:0]       p;
    logic [3:0]       off;
    logic [DataW-1:0] d;
    logic [AddrW-1:0] a;
    mode_e            tm;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: send(MODE_SND_RD, page_addr(4'($urandom)), 8'($urandom));
      2, 3: begin
        off = 4'($urandom);
        d   = 8'($urandom);
        if (off >= REG_TARGET0 && off <= REG_TARGET2 && $urandom_range(0, 1) == 1)
          d = 8'($urandom_range(0, 7));
        send(MODE_SND_WR, page_addr(off), d);
      end
      4: begin
        // mailbox round trips in both directions
        a = 16'($urandom);
        send(MODE_HOST_WR, a, 8'($urandom));
        send(MODE_SND_RD, page_addr(REG_PORT0 | {2'b00, a[1:0]}), 8'($urandom));
        p = 2'($urandom);
        send(MODE_SND_WR, page_addr(REG_PORT0 | {2'b00, p}), 8'($urandom));
        send(MODE_HOST_RD, {14'($urandom), p}, 8'($urandom));
      end
      5: begin
        // program a timer, run it, read its output
        t = $urandom_range(0, 2);
        d = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        send(MODE_SND_WR, page_addr(REG_TARGET0 + 4'(t)), d);
        d    = 8'($urandom);
        d[t] = 1'b1;
        if ($urandom_range(0, 1) == 1) begin
          d[t] = 1'b0;
          send(MODE_SND_WR, page_addr(REG_CONTROL), d);
          d[t] = 1'b1;
        end
        send(MODE_SND_WR, page_addr(REG_CONTROL), d);
        tm = (t == 2) ? MODE_FAST_TCK : MODE_PRES_TCK;
        n  = $urandom_range(1, (t == 2) ? 40 : 60);
        repeat (n) send(tm, 16'($urandom), 8'($urandom));
        send(MODE_SND_RD, page_addr(REG_OUT0 + 4'(t)), 8'($urandom));
      end
      6, 7: begin
        repeat ($urandom_range(1, 8)) begin
          tm = ($urandom_range(0, 1) == 1) ? MODE_PRES_TCK : MODE_FAST_TCK;
          send(tm, 16'($urandom), 8'($urandom));
        end
      end
      8: begin
        // ram and ipl area, sometimes near the top of memory
        a = 16'($urandom);
        if ($urandom_range(0, 1) == 1) a[15:6] = '1;
        tm = ($urandom_range(0, 1) == 1) ? MODE_SND_RD : MODE_SND_WR;
        send(tm, a, 8'($urandom));
      end
      default: begin
        // control write then look at what it cleared
        send(MODE_SND_WR, page_addr(REG_CONTROL), 8'($urandom));
        repeat (2)
          send(MODE_SND_RD, page_addr(REG_PORT0 | 4'($urandom_range(0, 3))), 8'($urandom));
        send(MODE_SND_RD, page_addr(REG_OUT0 + 4'($urandom_range(0, 2))), 8'($urandom));
      end
    endcase
  endtask

  initial begin : stimulus
    int start;
    sb = new();
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.address    = '0;
    in_if.write_data = '0;
    items_sent = 0;
    burst_left = 6;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: decode corners, mailbox, dsp access and the timers
    send(MODE_SND_RD, page_addr(REG_SPARE), 8'h00);
    send(MODE_SND_RD, IplBase, 8'hFF);
    send(MODE_SND_RD, 16'hFFFF, 8'h00);
    send(MODE_SND_RD, 16'h0000, 8'hFF);
    send(MODE_SND_RD, 16'h01F2, 8'h00);
    send(MODE_SND_WR, page_addr(REG_DSP_ADDR), 8'hFF);
    send(MODE_SND_RD, page_addr(REG_DSP_ADDR), 8'h00);
    send(MODE_SND_RD, page_addr(REG_DSP_DATA), 8'h00);
    send(MODE_SND_WR, page_addr(REG_DSP_DATA), 8'h5A);
    send(MODE_HOST_WR, 16'hFFFF, 8'hFF);
    send(MODE_SND_RD, page_addr(REG_PORT3), 8'h00);
    send(MODE_SND_WR, page_addr(REG_PORT0), 8'hA5);
    send(MODE_HOST_RD, 16'hFFFC, 8'h00);
    send(MODE_SND_WR, page_addr(REG_AUX1), 8'h00);
    send(MODE_SND_RD, page_addr(REG_AUX1), 8'h00);
    send(MODE_SND_WR, page_addr(REG_TARGET2), 8'h02);
    send(MODE_SND_WR, page_addr(REG_CONTROL), 8'hFF);
    send(MODE_SND_RD, page_addr(REG_PORT3), 8'h00);
    repeat (2) send(MODE_FAST_TCK, 16'h0000, 8'h00);
    repeat (4) send(MODE_PRES_TCK, 16'hFFFF, 8'hFF);
    send(MODE_SND_RD, page_addr(REG_OUT2), 8'h00);
    send(MODE_SND_WR, page_addr(REG_CONTROL), 8'h30);
    send(MODE_SND_RD, IplBase, 8'h00);
    send(MODE_SND_WR, page_addr(REG_OUT0), 8'hFF);

    // target of zero: the fast timer wraps through 256 counts
    send(MODE_SND_WR, page_addr(REG_TARGET2), 8'h00);
    send(MODE_SND_WR, page_addr(REG_CONTROL), 8'h84);
    repeat (257) send(MODE_FAST_TCK, 16'($urandom), 8'($urandom));
    send(MODE_SND_RD, page_addr(REG_OUT2), 8'h00);

    // random traffic
    start = items_sent;
    while (items_sent - start < RandomItems) random_sequence();

    // drain
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d transfers: %0d sound reads, %0d sound writes, %0d host, %0d ticks",
             items_sent, sb.by_mode[int'(MODE_SND_RD)], sb.by_mode[int'(MODE_SND_WR)],
             sb.by_mode[int'(MODE_HOST_RD)] + sb.by_mode[int'(MODE_HOST_WR)],
             sb.by_mode[int'(MODE_PRES_TCK)] + sb.by_mode[int'(MODE_FAST_TCK)]);
    $display("%0d replies checked, %0d timer periods completed, %0d mismatches",
             sb.replies, sb.periods, sb.errors);
    if (sb.errors == 0) begin
      $display("sound_cpu_io_timer_registers verification clean");
    end else begin
      $display("sound_cpu_io_timer_registers verification failed");
    end
    $finish;
  end

endmodule
